/* sv/sliding_window_event_limiter_unit_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent check helpers for the sliding window event limiter.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_EVENT_LIMITER_UNIT_DEFINES_SVH
`define SLIDING_WINDOW_EVENT_LIMITER_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SWL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SWL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/swl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swl_pkg
// Shared types, limits and constants of the sliding window event limiter.
// ----------------------------------------------------------------------------
package swl_pkg;

  localparam int SWL_SOURCES      = 16;
  localparam int SWL_CREATE_SLOTS = 128;
  localparam int SWL_UPDATE_SLOTS = 2048;
  localparam int SWL_GLOBAL_SLOTS = 256;

  localparam int SWL_SLOT_W   = 4;
  localparam int SWL_QDEPTH   = 2;

  localparam logic [31:0] SWL_WINDOW_RST = 32'd10000;
  localparam logic [8:0]  SWL_GLIMIT_RST = 9'd200;

  typedef enum logic [0:0] {
    CFG_WINDOW = 1'b0,
    CFG_GLIMIT = 1'b1
  } swl_cfg_idx_e;

  typedef enum logic [2:0] {
    RSN_OK         = 3'd0,
    RSN_ACTIVE     = 3'd1,
    RSN_SRC_CREATE = 3'd2,
    RSN_GLOBAL     = 3'd3,
    RSN_UPDATE     = 3'd4
  } swl_reason_e;

  typedef enum logic [1:0] {
    TC_TRUSTED   = 2'd0,
    TC_USER      = 2'd1,
    TC_UNTRUSTED = 2'd2
  } swl_trust_e;

  localparam logic MODE_CREATE = 1'b0;
  localparam logic MODE_UPDATE = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [3:0]  source_slot;
    logic [1:0]  trust_class;
    logic [15:0] live_events;
    logic [31:0] timestamp;
  } swl_req_t;

  typedef struct packed {
    logic       allowed;
    logic [2:0] reason;
    logic [4:0] limited_sources;
  } swl_res_t;

  typedef struct packed {
    logic [31:0] window_ticks;
    logic [8:0]  global_create_limit;
  } swl_cfg_t;

  function automatic logic [15:0] lim_create(logic [1:0] tc);
    logic [15:0] v;
    case (tc)
      TC_TRUSTED: v = 16'd120;
      TC_USER:    v = 16'd30;
      default:    v = 16'd10;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] lim_update(logic [1:0] tc);
    logic [15:0] v;
    case (tc)
      TC_TRUSTED: v = 16'd1200;
      TC_USER:    v = 16'd300;
      default:    v = 16'd100;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] lim_active(logic [1:0] tc);
    logic [15:0] v;
    case (tc)
      TC_TRUSTED: v = 16'd256;
      TC_USER:    v = 16'd64;
      default:    v = 16'd32;
    endcase
    return v;
  endfunction

endpackage

/* sv/sliding_window_event_limiter_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_event_limiter_unit
// Per-source and global sliding window limiter for create and update events.
// ----------------------------------------------------------------------------
// A command is taken on a rising edge with start high and busy low; a two
// entry queue holds commands while the back end works, so busy only rises
// when that queue is full. Each command yields one verdict on res_o, shown
// for exactly one cycle with res_valid_o high; the receiver cannot stall, so
// it must take every verdict in the cycle it is shown. The back end reads one
// log entry per step from its log memories (registered read, one port each):
// a command leaves idle, takes a read step per log checked, a compare step
// per non-empty log checked and a read and compare step per expired entry
// dropped, then a decide step; a create checks its source log and the global
// log, an update only its source log, and every logged time is dropped only once.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect at
// the next edge and must only happen while no command is in flight. Logs
// need no clearing pass: only entries counted by a fill are ever read.
// ----------------------------------------------------------------------------
`include "sliding_window_event_limiter_unit_defines.svh"

module sliding_window_event_limiter_unit #(
  parameter int SOURCES      = swl_pkg::SWL_SOURCES,
  parameter int CREATE_SLOTS = swl_pkg::SWL_CREATE_SLOTS,
  parameter int UPDATE_SLOTS = swl_pkg::SWL_UPDATE_SLOTS,
  parameter int GLOBAL_SLOTS = swl_pkg::SWL_GLOBAL_SLOTS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  swl_pkg::swl_req_t req_i,
  output logic              res_valid_o,
  output swl_pkg::swl_res_t res_o,
  input  logic              cfg_we_i,
  input  logic [0:0]        cfg_idx_i,
  input  logic [31:0]       cfg_wdata_i
);

  // Configuration registers.
  swl_pkg::swl_cfg_t cfg_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_ticks        <= swl_pkg::SWL_WINDOW_RST;
      cfg_q.global_create_limit <= swl_pkg::SWL_GLIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        swl_pkg::CFG_WINDOW: cfg_q.window_ticks        <= cfg_wdata_i;
        swl_pkg::CFG_GLIMIT: cfg_q.global_create_limit <= cfg_wdata_i[8:0];
        default: ;
      endcase
    end
  end

  // Front end to back end queue transfer.
  logic              q_valid, q_pop;
  swl_pkg::swl_req_t q_item;

  swl_front #(.SOURCES(SOURCES)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .req_i     (req_i),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  swl_back #(
    .SOURCES      (SOURCES),
    .CREATE_SLOTS (CREATE_SLOTS),
    .UPDATE_SLOTS (UPDATE_SLOTS),
    .GLOBAL_SLOTS (GLOBAL_SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  logic res_ok;
  assign res_ok = (res_o.reason == swl_pkg::RSN_OK);

  // Verdict and reason must agree.
  `SWL_ASSERT_NOW(a_allowed_ok, res_valid_o, res_o.allowed == res_ok, "allowed disagrees with reason")
  // Verdicts never come back to back: each command passes idle, read and decide states.
  `SWL_ASSERT_NEXT(a_no_double, res_valid_o, !res_valid_o, "verdicts on consecutive cycles")
  // A pop only happens when the queue holds a command.
  `SWL_ASSERT_NOW(a_pop_valid, q_pop, q_valid, "pop from empty queue")

endmodule

/* sv/swl_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swl_front
// Takes commands, folds slot and trust class, queues them for the back end.
// ----------------------------------------------------------------------------
module swl_front #(
  parameter int SOURCES = swl_pkg::SWL_SOURCES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  swl_pkg::swl_req_t req_i,
  output logic              q_valid_o,
  output swl_pkg::swl_req_t q_item_o,
  input  logic              q_pop_i
);

  localparam int NMAP = 2 ** swl_pkg::SWL_SLOT_W;
  localparam int QD   = swl_pkg::SWL_QDEPTH;
  localparam int QP_W = (QD > 1) ? $clog2(QD) : 1;
  localparam int QC_W = $clog2(QD + 1);

  logic [swl_pkg::SWL_SLOT_W-1:0] slot_map [NMAP];

  for (genvar g = 0; g < NMAP; g++) begin : g_map
    assign slot_map[g] = swl_pkg::SWL_SLOT_W'(g % SOURCES);
  end

  swl_pkg::swl_req_t item;
  always_comb begin
    item             = req_i;
    item.source_slot = slot_map[req_i.source_slot];
    if (req_i.trust_class == 2'd3) item.trust_class = swl_pkg::TC_UNTRUSTED;
  end

  swl_pkg::swl_req_t q_mem [QD];
  logic [QP_W-1:0]   wr_q, rd_q;
  logic [QC_W-1:0]   cnt_q;
  logic              push;

  assign busy      = (cnt_q == QC_W'(QD));
  assign push      = start && !busy;
  assign q_valid_o = (cnt_q != '0);
  assign q_item_o  = q_mem[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == QP_W'(QD - 1)) ? '0 : wr_q + 1'b1;
      if (q_pop_i) rd_q <= (rd_q == QP_W'(QD - 1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + QC_W'(push) - QC_W'(q_pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_q] <= item;
  end

endmodule

/* sv/swl_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swl_back
// Prunes the logs one entry per step, checks the limits, logs the grant.
// ----------------------------------------------------------------------------
module swl_back #(
  parameter int SOURCES      = swl_pkg::SWL_SOURCES,
  parameter int CREATE_SLOTS = swl_pkg::SWL_CREATE_SLOTS,
  parameter int UPDATE_SLOTS = swl_pkg::SWL_UPDATE_SLOTS,
  parameter int GLOBAL_SLOTS = swl_pkg::SWL_GLOBAL_SLOTS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  swl_pkg::swl_cfg_t cfg_i,
  input  logic              q_valid_i,
  input  swl_pkg::swl_req_t q_item_i,
  output logic              q_pop_o,
  output logic              res_valid_o,
  output swl_pkg::swl_res_t res_o
);

  localparam int SW    = (SOURCES > 1) ? $clog2(SOURCES) : 1;
  localparam int CH_W  = $clog2(CREATE_SLOTS);
  localparam int CF_W  = $clog2(CREATE_SLOTS + 1);
  localparam int UH_W  = $clog2(UPDATE_SLOTS);
  localparam int UF_W  = $clog2(UPDATE_SLOTS + 1);
  localparam int GH_W  = $clog2(GLOBAL_SLOTS);
  localparam int GF_W  = $clog2(GLOBAL_SLOTS + 1);
  localparam int CA_W  = $clog2(SOURCES * CREATE_SLOTS);
  localparam int UA_W  = $clog2(SOURCES * UPDATE_SLOTS);
  localparam int TOT_W = $clog2(SOURCES + 1);

  typedef enum logic [1:0] {S_IDLE, S_RD, S_CMP, S_DEC} state_e;
  typedef enum logic [1:0] {P_CRE, P_GLB, P_UPD} tgt_e;

  state_e state_q;
  tgt_e   tgt_q;

  logic        mode_q;
  logic [SW-1:0] slot_q;
  logic [1:0]  tc_q;
  logic [15:0] active_q;
  logic [31:0] now_q;

  logic [CH_W-1:0] cre_head_q [SOURCES];
  logic [CF_W-1:0] cre_fill_q [SOURCES];
  logic [UH_W-1:0] upd_head_q [SOURCES];
  logic [UF_W-1:0] upd_fill_q [SOURCES];
  logic [GH_W-1:0] glb_head_q;
  logic [GF_W-1:0] glb_fill_q;
  logic            refused_q  [SOURCES];
  logic [TOT_W-1:0] total_q;

  logic [31:0] cre_mem [SOURCES * CREATE_SLOTS];
  logic [31:0] upd_mem [SOURCES * UPDATE_SLOTS];
  logic [31:0] glb_mem [GLOBAL_SLOTS];
  logic [31:0] cre_rd_q, upd_rd_q, glb_rd_q;

  // Current source entries.
  logic [CH_W-1:0] ch;
  logic [CF_W-1:0] cf;
  logic [UH_W-1:0] uh;
  logic [UF_W-1:0] uf;
  assign ch = cre_head_q[slot_q];
  assign cf = cre_fill_q[slot_q];
  assign uh = upd_head_q[slot_q];
  assign uf = upd_fill_q[slot_q];

  // Tail positions for appends: head + fill, wrapped once.
  logic [CF_W:0]   c_sum;
  logic [UF_W:0]   u_sum;
  logic [GF_W:0]   g_sum;
  logic [CH_W-1:0] c_tail;
  logic [UH_W-1:0] u_tail;
  logic [GH_W-1:0] g_tail;
  always_comb begin
    c_sum  = (CF_W + 1)'(ch) + (CF_W + 1)'(cf);
    u_sum  = (UF_W + 1)'(uh) + (UF_W + 1)'(uf);
    g_sum  = (GF_W + 1)'(glb_head_q) + (GF_W + 1)'(glb_fill_q);
    c_tail = CH_W'((c_sum >= (CF_W + 1)'(CREATE_SLOTS)) ? c_sum - (CF_W + 1)'(CREATE_SLOTS)
                                                         : c_sum);
    u_tail = UH_W'((u_sum >= (UF_W + 1)'(UPDATE_SLOTS)) ? u_sum - (UF_W + 1)'(UPDATE_SLOTS)
                                                         : u_sum);
    g_tail = GH_W'((g_sum >= (GF_W + 1)'(GLOBAL_SLOTS)) ? g_sum - (GF_W + 1)'(GLOBAL_SLOTS)
                                                         : g_sum);
  end

  logic [CA_W-1:0] c_base, c_raddr, c_waddr;
  logic [UA_W-1:0] u_base, u_raddr, u_waddr;
  assign c_base  = CA_W'(slot_q) * CA_W'(CREATE_SLOTS);
  assign u_base  = UA_W'(slot_q) * UA_W'(UPDATE_SLOTS);
  assign c_raddr = c_base + CA_W'(ch);
  assign c_waddr = c_base + CA_W'(c_tail);
  assign u_raddr = u_base + UA_W'(uh);
  assign u_waddr = u_base + UA_W'(u_tail);

  // Prune step on the current target.
  logic        tgt_empty;
  logic [31:0] tgt_data;
  logic        expired;
  always_comb begin
    case (tgt_q)
      P_CRE:   begin tgt_empty = (cf == '0);         tgt_data = cre_rd_q; end
      P_GLB:   begin tgt_empty = (glb_fill_q == '0); tgt_data = glb_rd_q; end
      default: begin tgt_empty = (uf == '0);         tgt_data = upd_rd_q; end
    endcase
    expired = ((now_q - tgt_data) >= cfg_i.window_ticks);
  end

  // Verdict.
  swl_pkg::swl_reason_e rsn;
  logic                 grant;
  always_comb begin
    rsn = swl_pkg::RSN_OK;
    if (mode_q == swl_pkg::MODE_CREATE) begin
      if (active_q >= swl_pkg::lim_active(tc_q)) begin
        rsn = swl_pkg::RSN_ACTIVE;
      end else if (32'(cf) >= 32'(swl_pkg::lim_create(tc_q)) ||
                   32'(cf) >= 32'(CREATE_SLOTS)) begin
        rsn = swl_pkg::RSN_SRC_CREATE;
      end else if (32'(glb_fill_q) >= 32'(cfg_i.global_create_limit) ||
                   32'(glb_fill_q) >= 32'(GLOBAL_SLOTS)) begin
        rsn = swl_pkg::RSN_GLOBAL;
      end
    end else if (32'(uf) >= 32'(swl_pkg::lim_update(tc_q)) ||
                 32'(uf) >= 32'(UPDATE_SLOTS)) begin
      rsn = swl_pkg::RSN_UPDATE;
    end
    grant = (rsn == swl_pkg::RSN_OK);
  end

  logic dec, c_we, u_we;
  assign dec  = (state_q == S_DEC);
  assign c_we = dec && grant && (mode_q == swl_pkg::MODE_CREATE);
  assign u_we = dec && grant && (mode_q != swl_pkg::MODE_CREATE);

  logic [TOT_W-1:0] total_d;
  always_comb begin
    total_d = total_q;
    if (!grant && !refused_q[slot_q]) total_d = total_q + 1'b1;
    else if (grant && refused_q[slot_q]) total_d = total_q - 1'b1;
  end

  assign q_pop_o = (state_q == S_IDLE) && q_valid_i;

  always_ff @(posedge clk_i) begin
    if (c_we) cre_mem[c_waddr] <= now_q;
    if (u_we) upd_mem[u_waddr] <= now_q;
    if (c_we) glb_mem[g_tail] <= now_q;
    cre_rd_q <= cre_mem[c_raddr];
    upd_rd_q <= upd_mem[u_raddr];
    glb_rd_q <= glb_mem[glb_head_q];
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      mode_q   <= q_item_i.mode;
      slot_q   <= SW'(q_item_i.source_slot);
      tc_q     <= q_item_i.trust_class;
      active_q <= q_item_i.live_events;
      now_q    <= q_item_i.timestamp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tgt_q       <= P_CRE;
      glb_head_q  <= '0;
      glb_fill_q  <= '0;
      total_q     <= '0;
      res_valid_o <= 1'b0;
      res_o       <= '0;
      for (int i = 0; i < SOURCES; i++) begin
        cre_head_q[i] <= '0;
        cre_fill_q[i] <= '0;
        upd_head_q[i] <= '0;
        upd_fill_q[i] <= '0;
        refused_q[i]  <= 1'b0;
      end
    end else begin
      res_valid_o <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            tgt_q   <= (q_item_i.mode == swl_pkg::MODE_CREATE) ? P_CRE : P_UPD;
            state_q <= S_RD;
          end
        end
        S_RD: begin
          if (!tgt_empty) state_q <= S_CMP;
          else if (tgt_q == P_CRE) tgt_q <= P_GLB;
          else state_q <= S_DEC;
        end
        S_CMP: begin
          if (expired) begin
            case (tgt_q)
              P_CRE: begin
                cre_head_q[slot_q] <= (ch == CH_W'(CREATE_SLOTS - 1)) ? '0 : ch + 1'b1;
                cre_fill_q[slot_q] <= cf - 1'b1;
              end
              P_GLB: begin
                glb_head_q <= (glb_head_q == GH_W'(GLOBAL_SLOTS - 1)) ? '0
                                                                      : glb_head_q + 1'b1;
                glb_fill_q <= glb_fill_q - 1'b1;
              end
              default: begin
                upd_head_q[slot_q] <= (uh == UH_W'(UPDATE_SLOTS - 1)) ? '0 : uh + 1'b1;
                upd_fill_q[slot_q] <= uf - 1'b1;
              end
            endcase
            state_q <= S_RD;
          end else if (tgt_q == P_CRE) begin
            tgt_q   <= P_GLB;
            state_q <= S_RD;
          end else begin
            state_q <= S_DEC;
          end
        end
        S_DEC: begin
          if (c_we) begin
            cre_fill_q[slot_q] <= cf + 1'b1;
            glb_fill_q         <= glb_fill_q + 1'b1;
          end
          if (u_we) upd_fill_q[slot_q] <= uf + 1'b1;
          refused_q[slot_q]     <= !grant;
          total_q               <= total_d;
          res_valid_o           <= 1'b1;
          res_o.allowed         <= grant;
          res_o.reason          <= rsn;
          res_o.limited_sources <= 5'(total_d);
          state_q               <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
